/* rtl/paa_pkg.sv */
package paa_pkg;

    localparam int unsigned WINDOW   = 5;
    localparam int unsigned CNT_W    = $clog2(WINDOW + 1);
    localparam int unsigned DIST_W   = 9;
    localparam int unsigned PER_W    = 16;
    localparam int unsigned SUM_W    = $clog2(511 * WINDOW + 1);
    localparam int unsigned PROD_W   = DIST_W + CNT_W;
    localparam int unsigned CMP_W    = (SUM_W > PROD_W) ? SUM_W : PROD_W;
    localparam int unsigned NUM_REGS = 7;
    localparam int unsigned IDX_W    = $clog2(NUM_REGS);
    localparam int unsigned ADDR_W   = IDX_W + 2;

    // cm = (echo_us * 1124) >> 16, i.e. echo_us * 0.01715
    localparam logic [10:0] CM_SCALE = 11'd1124;

    localparam logic [7:0] INTEN_CRITICAL = 8'd255;
    localparam logic [7:0] INTEN_WARNING  = 8'd128;
    localparam logic [7:0] INTEN_CAUTION  = 8'd64;

    localparam logic OP_ECHO = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [1:0] {
        LVL_NORMAL   = 2'd0,
        LVL_CAUTION  = 2'd1,
        LVL_WARNING  = 2'd2,
        LVL_CRITICAL = 2'd3
    } level_t;

    typedef enum logic [IDX_W-1:0] {
        REG_CRITICAL_CM  = 3'd0,
        REG_WARNING_CM   = 3'd1,
        REG_CAUTION_CM   = 3'd2,
        REG_MAX_RANGE_CM = 3'd3,
        REG_CRITICAL_PER = 3'd4,
        REG_WARNING_PER  = 3'd5,
        REG_CAUTION_PER  = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [PER_W-1:0] critical_per;
        logic [PER_W-1:0] warning_per;
        logic [PER_W-1:0] caution_per;
    } period_cfg_t;

endpackage

/* rtl/paa_cell.sv */
module paa_cell (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       shift_en,
    input  logic [paa_pkg::DIST_W-1:0] dist_in,
    output logic [paa_pkg::DIST_W-1:0] dist_out
);

    logic [paa_pkg::DIST_W-1:0] dist_reg;
    logic [paa_pkg::DIST_W-1:0] dist_next;

    always_comb begin
        dist_next = dist_reg;
        if (shift_en) begin
            dist_next = dist_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_reg <= '0;
        end else begin
            dist_reg <= dist_next;
        end
    end

    assign dist_out = dist_reg;

endmodule

/* rtl/paa_buzzer.sv */
module paa_buzzer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 tick,
    input  paa_pkg::level_t      level,
    input  paa_pkg::period_cfg_t periods,
    output logic [7:0]           drive_next
);

    logic [paa_pkg::PER_W-1:0] elapsed_reg;
    logic [paa_pkg::PER_W-1:0] elapsed_next;
    logic                      phase_reg;
    logic                      phase_next;
    logic [7:0]                drive_reg;
    logic [paa_pkg::PER_W-1:0] elapsed_inc;
    logic [paa_pkg::PER_W-1:0] period;
    logic [7:0]                inten;

    always_comb begin
        unique case (level)
            paa_pkg::LVL_CRITICAL: begin
                period = periods.critical_per;
                inten  = paa_pkg::INTEN_CRITICAL;
            end
            paa_pkg::LVL_WARNING: begin
                period = periods.warning_per;
                inten  = paa_pkg::INTEN_WARNING;
            end
            default: begin
                period = periods.caution_per;
                inten  = paa_pkg::INTEN_CAUTION;
            end
        endcase
    end

    always_comb begin
        elapsed_inc  = (&elapsed_reg) ? elapsed_reg : elapsed_reg + 1'b1;
        elapsed_next = elapsed_reg;
        phase_next   = phase_reg;
        drive_next   = drive_reg;
        if (tick) begin
            elapsed_next = elapsed_inc;
            if (level == paa_pkg::LVL_NORMAL) begin
                drive_next = '0;
            end else if (elapsed_inc >= period) begin
                elapsed_next = '0;
                phase_next   = ~phase_reg;
                drive_next   = phase_next ? inten : 8'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elapsed_reg <= '0;
            phase_reg   <= 1'b0;
            drive_reg   <= '0;
        end else begin
            elapsed_reg <= elapsed_next;
            phase_reg   <= phase_next;
            drive_reg   <= drive_next;
        end
    end

endmodule

/* rtl/proximity_alarm_averager.sv */
// Proximity alarm averager. Each item is either an echo sample (op 0), which
// converts the echo time to cm, pushes it through a row of window cells and
// re-grades the alarm level from the running sum, or a millisecond tick
// (op 1), which steps the buzzer timer. Every item yields one result item in
// the cycle after it is accepted; one item is taken every cycle while no held
// result waits on m_ready, since the result register hands off to the output
// while the next item is accepted. The window shifts one cell per sample.
// Configuration registers sit at byte address 4*index on the APB port.
module proximity_alarm_averager (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [paa_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_op,
    input  logic [15:0]                 s_echo_us,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_level,
    output logic                        m_led_green,
    output logic                        m_led_yellow,
    output logic                        m_led_red,
    output logic [7:0]                  m_buzzer_drive,
    output logic [8:0]                  m_distance_cm,
    output logic [11:0]                 m_window_sum,
    output logic [2:0]                  m_window_count
);

    localparam int unsigned DW = paa_pkg::DIST_W;

    // configuration
    logic [DW-1:0]        crit_cm_reg, warn_cm_reg, caut_cm_reg, max_cm_reg;
    paa_pkg::period_cfg_t periods_reg;
    paa_pkg::reg_idx_t    cfg_idx;
    logic                 cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paa_pkg::reg_idx_t'(paddr[paa_pkg::ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crit_cm_reg              <= 9'd10;
            warn_cm_reg              <= 9'd20;
            caut_cm_reg              <= 9'd30;
            max_cm_reg               <= 9'd400;
            periods_reg.critical_per <= 16'd200;
            periods_reg.warning_per  <= 16'd500;
            periods_reg.caution_per  <= 16'd1000;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                paa_pkg::REG_CRITICAL_CM:  crit_cm_reg              <= pwdata[DW-1:0];
                paa_pkg::REG_WARNING_CM:   warn_cm_reg              <= pwdata[DW-1:0];
                paa_pkg::REG_CAUTION_CM:   caut_cm_reg              <= pwdata[DW-1:0];
                paa_pkg::REG_MAX_RANGE_CM: max_cm_reg               <= pwdata[DW-1:0];
                paa_pkg::REG_CRITICAL_PER: periods_reg.critical_per <= pwdata[15:0];
                paa_pkg::REG_WARNING_PER:  periods_reg.warning_per  <= pwdata[15:0];
                paa_pkg::REG_CAUTION_PER:  periods_reg.caution_per  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            paa_pkg::REG_CRITICAL_CM:  prdata = {23'd0, crit_cm_reg};
            paa_pkg::REG_WARNING_CM:   prdata = {23'd0, warn_cm_reg};
            paa_pkg::REG_CAUTION_CM:   prdata = {23'd0, caut_cm_reg};
            paa_pkg::REG_MAX_RANGE_CM: prdata = {23'd0, max_cm_reg};
            paa_pkg::REG_CRITICAL_PER: prdata = {16'd0, periods_reg.critical_per};
            paa_pkg::REG_WARNING_PER:  prdata = {16'd0, periods_reg.warning_per};
            paa_pkg::REG_CAUTION_PER:  prdata = {16'd0, periods_reg.caution_per};
            default:                   prdata = '0;
        endcase
    end

    // handshake
    logic accept, sample, tick;
    logic out_valid_reg;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign sample  = accept && (s_op == paa_pkg::OP_ECHO);
    assign tick    = accept && (s_op == paa_pkg::OP_TICK);

    // distance conversion
    logic [26:0] echo_prod;
    logic [10:0] raw_cm;
    logic [DW-1:0] dist_cm;

    assign echo_prod = 27'(s_echo_us) * 27'(paa_pkg::CM_SCALE);
    assign raw_cm    = echo_prod[26:16];
    assign dist_cm   = (raw_cm == '0 || raw_cm > 11'(max_cm_reg)) ? max_cm_reg
                                                                 : raw_cm[DW-1:0];

    // window chain: newest enters cell 0, oldest leaves the last cell
    logic [DW-1:0] link [paa_pkg::WINDOW+1];

    assign link[0] = dist_cm;

    for (genvar i = 0; i < paa_pkg::WINDOW; i++) begin : g_cell
        paa_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (sample),
            .dist_in  (link[i]),
            .dist_out (link[i+1])
        );
    end

    // running sum, count and level
    logic [paa_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [paa_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    paa_pkg::level_t           level_reg, level_next;
    logic [DW-1:0]             last_dist_reg, last_dist_next;
    logic [paa_pkg::CMP_W-1:0] sum_cmp, crit_lim, warn_lim, caut_lim;

    always_comb begin
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        last_dist_next = last_dist_reg;
        if (sample) begin
            sum_next       = sum_reg - paa_pkg::SUM_W'(link[paa_pkg::WINDOW])
                           + paa_pkg::SUM_W'(dist_cm);
            last_dist_next = dist_cm;
            if (cnt_reg != paa_pkg::CNT_W'(paa_pkg::WINDOW)) begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    assign sum_cmp  = paa_pkg::CMP_W'(sum_next);
    assign crit_lim = paa_pkg::CMP_W'(paa_pkg::PROD_W'(crit_cm_reg)
                                      * paa_pkg::PROD_W'(cnt_next));
    assign warn_lim = paa_pkg::CMP_W'(paa_pkg::PROD_W'(warn_cm_reg)
                                      * paa_pkg::PROD_W'(cnt_next));
    assign caut_lim = paa_pkg::CMP_W'(paa_pkg::PROD_W'(caut_cm_reg)
                                      * paa_pkg::PROD_W'(cnt_next));

    always_comb begin
        level_next = level_reg;
        if (sample) begin
            if (cnt_next == '0) begin
                level_next = paa_pkg::LVL_NORMAL;
            end else if (sum_cmp <= crit_lim) begin
                level_next = paa_pkg::LVL_CRITICAL;
            end else if (sum_cmp <= warn_lim) begin
                level_next = paa_pkg::LVL_WARNING;
            end else if (sum_cmp <= caut_lim) begin
                level_next = paa_pkg::LVL_CAUTION;
            end else begin
                level_next = paa_pkg::LVL_NORMAL;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            cnt_reg       <= '0;
            level_reg     <= paa_pkg::LVL_NORMAL;
            last_dist_reg <= '0;
        end else begin
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            level_reg     <= level_next;
            last_dist_reg <= last_dist_next;
        end
    end

    // buzzer runs off the level held before this item
    logic [7:0] drive_next;

    paa_buzzer u_buzzer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tick       (tick),
        .level      (level_reg),
        .periods    (periods_reg),
        .drive_next (drive_next)
    );

    // result register
    paa_pkg::level_t     out_level_reg;
    logic [7:0]          out_drive_reg;
    logic [DW-1:0]       out_dist_reg;
    logic [11:0]         out_sum_reg;
    logic [2:0]          out_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_level_reg <= level_next;
            out_drive_reg <= drive_next;
            out_dist_reg  <= last_dist_next;
            out_sum_reg   <= 12'(sum_next);
            out_cnt_reg   <= 3'(cnt_next);
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_level        = out_level_reg;
    assign m_led_green    = (out_level_reg == paa_pkg::LVL_NORMAL)
                         || (out_level_reg == paa_pkg::LVL_CAUTION);
    assign m_led_yellow   = (out_level_reg == paa_pkg::LVL_CAUTION)
                         || (out_level_reg == paa_pkg::LVL_WARNING);
    assign m_led_red      = (out_level_reg == paa_pkg::LVL_CRITICAL);
    assign m_buzzer_drive = out_drive_reg;
    assign m_distance_cm  = out_dist_reg;
    assign m_window_sum   = out_sum_reg;
    assign m_window_count = out_cnt_reg;

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= paa_pkg::CNT_W'(paa_pkg::WINDOW))
        else $error("window count beyond depth");

    a_sum_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(sum_reg) <= 32'(511) * 32'(cnt_reg))
        else $error("running sum exceeds count times max distance");

    a_cnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        sample && (cnt_reg != paa_pkg::CNT_W'(paa_pkg::WINDOW))
        |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("sample did not advance window count");

    a_tick_holds_window: assert property (@(posedge aclk) disable iff (!aresetn)
        tick |=> $stable(sum_reg) && $stable(level_reg))
        else $error("tick disturbed window state");

    a_no_accept_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |-> !s_ready)
        else $error("item accepted over a held result");
`endif

endmodule

/* tb/proximity_alarm_averager_tb.sv */
`timescale 1ns / 1ps

module proximity_alarm_averager_tb;
    import paa_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    logic                aclk;
    logic                aresetn;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_valid;
    logic                s_ready;
    logic                s_op;
    logic [15:0]         s_echo_us;
    logic                m_valid;
    logic                m_ready;
    logic [1:0]          m_level;
    logic                m_led_green;
    logic                m_led_yellow;
    logic                m_led_red;
    logic [7:0]          m_buzzer_drive;
    logic [8:0]          m_distance_cm;
    logic [11:0]         m_window_sum;
    logic [2:0]          m_window_count;

    proximity_alarm_averager dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_echo_us      (s_echo_us),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_level        (m_level),
        .m_led_green    (m_led_green),
        .m_led_yellow   (m_led_yellow),
        .m_led_red      (m_led_red),
        .m_buzzer_drive (m_buzzer_drive),
        .m_distance_cm  (m_distance_cm),
        .m_window_sum   (m_window_sum),
        .m_window_count (m_window_count)
    );

    typedef struct packed {
        level_t      level;
        logic        green;
        logic        yellow;
        logic        red;
        logic [7:0]  drive;
        logic [8:0]  dist_cm;
        logic [11:0] sum;
        logic [2:0]  count;
    } alarm_out_t;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // local copy of the block's registers and state
    logic [8:0]  crit_cm  = 9'd10;
    logic [8:0]  warn_cm  = 9'd20;
    logic [8:0]  caut_cm  = 9'd30;
    logic [8:0]  max_cm   = 9'd400;
    logic [15:0] crit_per = 16'd200;
    logic [15:0] warn_per = 16'd500;
    logic [15:0] caut_per = 16'd1000;

    logic [8:0]  win_cells [WINDOW] = '{default: '0};
    int unsigned slot      = 0;
    bit          filled    = 1'b0;
    int unsigned sum_cm    = 0;
    level_t      cur_level = LVL_NORMAL;
    int unsigned ms_count  = 0;
    bit          phase_on  = 1'b0;
    logic [7:0]  duty_hold = '0;
    logic [8:0]  last_cm   = '0;

    alarm_out_t pending_alarms [$];

    int errors         = 0;
    int cycle_count    = 0;
    int hold_cycles    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    task automatic advance_alarm(input logic op, input logic [15:0] echo);
        int unsigned cm;
        int unsigned cnt;
        logic [15:0] per;
        logic [7:0]  inten;
        alarm_out_t  r;
        if (op == OP_ECHO) begin
            cm = (int'(echo) * 1124) >> 16;
            if (cm == 0 || cm > max_cm) cm = max_cm;
            last_cm = 9'(cm);
            sum_cm = sum_cm - win_cells[slot] + cm;
            win_cells[slot] = 9'(cm);
            slot++;
            if (slot >= WINDOW) begin
                slot = 0;
                filled = 1'b1;
            end
            cnt = filled ? WINDOW : slot;
            if (cnt == 0)                  cur_level = LVL_NORMAL;
            else if (sum_cm <= crit_cm * cnt) cur_level = LVL_CRITICAL;
            else if (sum_cm <= warn_cm * cnt) cur_level = LVL_WARNING;
            else if (sum_cm <= caut_cm * cnt) cur_level = LVL_CAUTION;
            else                           cur_level = LVL_NORMAL;
        end else begin
            if (ms_count < 16'hFFFF) ms_count++;
            if (cur_level == LVL_NORMAL) begin
                duty_hold = '0;
            end else begin
                case (cur_level)
                    LVL_CRITICAL: begin per = crit_per; inten = INTEN_CRITICAL; end
                    LVL_WARNING:  begin per = warn_per; inten = INTEN_WARNING;  end
                    default:      begin per = caut_per; inten = INTEN_CAUTION;  end
                endcase
                if (ms_count >= per) begin
                    ms_count = 0;
                    phase_on = !phase_on;
                    duty_hold = phase_on ? inten : 8'd0;
                end
            end
        end
        cnt = filled ? WINDOW : slot;
        r.level   = cur_level;
        r.green   = (cur_level == LVL_NORMAL || cur_level == LVL_CAUTION);
        r.yellow  = (cur_level == LVL_CAUTION || cur_level == LVL_WARNING);
        r.red     = (cur_level == LVL_CRITICAL);
        r.drive   = duty_hold;
        r.dist_cm = last_cm;
        r.sum     = 12'(sum_cm);
        r.count   = 3'(cnt);
        pending_alarms.push_back(r);
    endtask

    // lowest echo time that converts to exactly cm
    function automatic logic [15:0] echo_for_cm(input int unsigned cm);
        return 16'((cm * 65536 + 1123) / 1124);
    endfunction

    task automatic send_item(input logic op, input logic [15:0] echo);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_op      <= op;
        s_echo_us <= echo;
        do @(posedge aclk); while (!s_ready);
        advance_alarm(op, echo);
    endtask

    task automatic wait_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_alarms.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input reg_idx_t idx, input logic [15:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CRITICAL_CM:  crit_cm  = value[8:0];
            REG_WARNING_CM:   warn_cm  = value[8:0];
            REG_CAUTION_CM:   caut_cm  = value[8:0];
            REG_MAX_RANGE_CM: max_cm   = value[8:0];
            REG_CRITICAL_PER: crit_per = value;
            REG_WARNING_PER:  warn_per = value;
            REG_CAUTION_PER:  caut_per = value;
            default: ;
        endcase
    endtask

    // receiver side: random stalls plus an optional long hold-off
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                hold_cycles--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        alarm_out_t got;
        alarm_out_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{level_t'(m_level), m_led_green, m_led_yellow, m_led_red,
                    m_buzzer_drive, m_distance_cm, m_window_sum, m_window_count};
            if (pending_alarms.size() == 0) begin
                errors++;
                if (errors <= 10) $display("result item with nothing pending");
            end else begin
                want = pending_alarms.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: lvl %0d/%0d grn %0d/%0d yel %0d/%0d ",
                                  "red %0d/%0d drv %0d/%0d cm %0d/%0d sum %0d/%0d ",
                                  "cnt %0d/%0d (exp/act)"},
                                 want.level, got.level, want.green, got.green,
                                 want.yellow, got.yellow, want.red, got.red,
                                 want.drive, got.drive, want.dist_cm, got.dist_cm,
                                 want.sum, got.sum, want.count, got.count);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ticks before any sample; echo field must be ignored
    task automatic test_ticks_before_samples();
        send_item(OP_TICK, 16'h0000);
        send_item(OP_TICK, 16'hFFFF);
        wait_drain();
    endtask

    // zero echo, sub-1cm echo, first 1 cm echo, exact max range, one past it, full scale, then 1 us
    task automatic test_echo_extremes();
        send_item(OP_ECHO, 16'd0);
        send_item(OP_ECHO, 16'd58);
        send_item(OP_ECHO, 16'd59);
        send_item(OP_ECHO, echo_for_cm(400));
        send_item(OP_ECHO, echo_for_cm(401));
        send_item(OP_ECHO, 16'hFFFF);
        send_item(OP_ECHO, 16'd1);
        wait_drain();
    endtask

    // zero max range forces every distance to 0; zero period toggles each tick
    task automatic test_zero_range_and_period();
        cfg_write(REG_MAX_RANGE_CM, 16'd0);
        cfg_write(REG_CRITICAL_CM, 16'd0);
        cfg_write(REG_CRITICAL_PER, 16'd0);
        repeat (5) send_item(OP_ECHO, 16'($urandom));
        repeat (2) send_item(OP_TICK, 16'($urandom));
        wait_drain();
    endtask

    // window all zero here: step through warning, caution and normal
    task automatic test_level_steps();
        cfg_write(REG_MAX_RANGE_CM, 16'd400);
        cfg_write(REG_CRITICAL_CM, 16'd10);
        cfg_write(REG_WARNING_PER, 16'd1);
        cfg_write(REG_CAUTION_PER, 16'd2);
        send_item(OP_ECHO, echo_for_cm(60));
        repeat (2) send_item(OP_TICK, 16'd0);
        send_item(OP_ECHO, echo_for_cm(60));
        repeat (2) send_item(OP_TICK, 16'd0);
        send_item(OP_ECHO, 16'd0);
        send_item(OP_TICK, 16'd0);
        wait_drain();
    endtask

    // elapsed count keeps running while in normal, so the first tick after
    // entering critical toggles at once
    task automatic test_elapsed_in_normal();
        cfg_write(REG_CRITICAL_CM, 16'd10);
        repeat (5) send_item(OP_ECHO, 16'd0);
        repeat (150) send_item(OP_TICK, 16'd0);
        wait_drain();
        cfg_write(REG_CRITICAL_CM, 16'd511);
        cfg_write(REG_CRITICAL_PER, 16'd100);
        send_item(OP_ECHO, echo_for_cm(200));
        repeat (2) send_item(OP_TICK, 16'd0);
        wait_drain();
    endtask

    task automatic send_random_item();
        int unsigned pick;
        int unsigned top;
        int unsigned cm;
        pick = $urandom_range(99);
        if (pick < 35) begin
            send_item(OP_TICK, 16'($urandom));
        end else if (pick < 88) begin
            top = caut_cm + 20;
            if (top > 511) top = 511;
            cm = $urandom_range(top, 0);
            send_item(OP_ECHO, (cm == 0) ? 16'd0 : echo_for_cm(cm) + 16'($urandom_range(50)));
        end else begin
            send_item(OP_ECHO, 16'($urandom));
        end
    endtask

    task automatic test_random_phases();
        int unsigned c;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                1: begin
                    // all thresholds at top: always critical
                    cfg_write(REG_CRITICAL_CM, 16'd511);
                    cfg_write(REG_WARNING_CM, 16'd511);
                    cfg_write(REG_CAUTION_CM, 16'd511);
                    cfg_write(REG_MAX_RANGE_CM, 16'd511);
                    cfg_write(REG_CRITICAL_PER, 16'd1);
                    cfg_write(REG_WARNING_PER, 16'hFFFF);
                    cfg_write(REG_CAUTION_PER, 16'hFFFF);
                end
                3: begin
                    // every distance is 1 cm: caution only, slowest period
                    cfg_write(REG_CRITICAL_CM, 16'd0);
                    cfg_write(REG_WARNING_CM, 16'd0);
                    cfg_write(REG_CAUTION_CM, 16'd511);
                    cfg_write(REG_MAX_RANGE_CM, 16'd1);
                    cfg_write(REG_CRITICAL_PER, 16'd0);
                    cfg_write(REG_CAUTION_PER, 16'hFFFF);
                end
                default: begin
                    c = $urandom_range(40);
                    cfg_write(REG_CRITICAL_CM, 16'(c));
                    c = c + $urandom_range(30);
                    cfg_write(REG_WARNING_CM, 16'(c));
                    c = c + $urandom_range(30);
                    cfg_write(REG_CAUTION_CM, 16'(c));
                    cfg_write(REG_MAX_RANGE_CM, 16'($urandom_range(511, 60)));
                    cfg_write(REG_CRITICAL_PER, 16'($urandom_range(15, 1)));
                    cfg_write(REG_WARNING_PER, 16'($urandom_range(15, 1)));
                    cfg_write(REG_CAUTION_PER, 16'($urandom_range(15, 1)));
                end
            endcase
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            repeat (250) send_random_item();
            wait_drain();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // long receiver hold-off while items keep coming: input must stall
    task automatic test_output_backpressure();
        cfg_write(REG_CRITICAL_CM, 16'd10);
        cfg_write(REG_WARNING_CM, 16'd20);
        cfg_write(REG_CAUTION_CM, 16'd30);
        cfg_write(REG_MAX_RANGE_CM, 16'd400);
        hold_cycles = 300;
        repeat (60) send_random_item();
        wait_drain();
    endtask

    initial begin
        aresetn   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        s_valid   = 1'b0;
        s_op      = OP_ECHO;
        s_echo_us = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_ticks_before_samples();
        test_echo_extremes();
        test_zero_range_and_period();
        test_level_steps();
        test_elapsed_in_normal();
        test_random_phases();
        test_output_backpressure();

        wait_drain();
        repeat (10) @(posedge aclk);
        errors += pending_alarms.size();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* proximity_alarm_averager.f */
rtl/paa_pkg.sv
rtl/paa_cell.sv
rtl/paa_buzzer.sv
rtl/proximity_alarm_averager.sv
tb/proximity_alarm_averager_tb.sv
